// ----- rtl/parent_linked_forest_table_core_defines.svh -----
// assertion macros of the forest table datapath
`ifndef PARENT_LINKED_FOREST_TABLE_CORE_DEFINES_SVH
`define PARENT_LINKED_FOREST_TABLE_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PLFT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("forest table check failed");

// next-cycle implication, disabled during reset
`define PLFT_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("forest table check failed");

`endif

// ----- rtl/plft_pkg.sv -----
// shared constants, command codes and control structs of the forest table
package plft_pkg;

    localparam int CAPACITY_DEF       = 128;
    localparam int MAX_DEPTH_DEF      = 16;
    localparam int ANCESTOR_STEPS_DEF = 10;

    // parent id of a root
    localparam logic signed [16:0] ROOT_ID = -17'sd1;

    // operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DEPTH  = 2'd2;
    localparam logic [1:0] OP_SUBTREE = 2'd3;

    // datapath command codes
    localparam logic [4:0] C_NONE     = 5'd0;
    localparam logic [4:0] C_LOAD     = 5'd1;
    localparam logic [4:0] C_APP_RD   = 5'd2;
    localparam logic [4:0] C_APP_WR   = 5'd3;
    localparam logic [4:0] C_DEL_INIT = 5'd4;
    localparam logic [4:0] C_P_RD     = 5'd5;
    localparam logic [4:0] C_P_TAKE   = 5'd6;
    localparam logic [4:0] C_P_NEXT   = 5'd7;
    localparam logic [4:0] C_PASS     = 5'd8;
    localparam logic [4:0] C_I_RD     = 5'd9;
    localparam logic [4:0] C_I_CHK    = 5'd10;
    localparam logic [4:0] C_C_INIT   = 5'd11;
    localparam logic [4:0] C_C_RD     = 5'd12;
    localparam logic [4:0] C_C_WR     = 5'd13;
    localparam logic [4:0] C_C_END    = 5'd14;
    localparam logic [4:0] C_F_START  = 5'd15;
    localparam logic [4:0] C_F_RD     = 5'd16;
    localparam logic [4:0] C_F_HIT    = 5'd17;
    localparam logic [4:0] C_I_NEXT   = 5'd18;
    localparam logic [4:0] C_FIN      = 5'd19;

    typedef struct packed {
        logic [4:0] code;
        logic       set_ok;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       idx_ok;
        logic       full;
        logic       ptr_end;
        logic       p_end;
        logic       p_live;
        logic       hit;
        logic       hit_root;
        logic       key_neg1;
        logic       depth_max;
        logic       step_max;
        logic       req_root;
        logic       out_busy;
        logic       changed;
    } status_t;

endpackage

// ----- rtl/plft_ctrl.sv -----
// controller state machine sequencing the forest table operations
module plft_ctrl
    import plft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  status_t status,
    output cmd_t    cmd,
    output logic    in_stall
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_APP_WR = 5'd2;
    localparam logic [4:0] S_P_RD   = 5'd3;
    localparam logic [4:0] S_P_CHK  = 5'd4;
    localparam logic [4:0] S_I_RD   = 5'd5;
    localparam logic [4:0] S_I_CHK  = 5'd6;
    localparam logic [4:0] S_C_INIT = 5'd7;
    localparam logic [4:0] S_C_RD   = 5'd8;
    localparam logic [4:0] S_C_WR   = 5'd9;
    localparam logic [4:0] S_Q_TEST = 5'd10;
    localparam logic [4:0] S_T_TEST = 5'd11;
    localparam logic [4:0] S_F_RD   = 5'd12;
    localparam logic [4:0] S_F_CHK  = 5'd13;
    localparam logic [4:0] S_FIN    = 5'd14;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    // next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd.code   = C_NONE;
        cmd.set_ok = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.code   = C_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (status.op)
                    OP_APPEND:
                    begin
                        if (status.full)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.code   = C_APP_RD;
                            state_next = S_APP_WR;
                        end
                    end
                    OP_DELETE:
                    begin
                        if (status.idx_ok)
                        begin
                            cmd.code   = C_DEL_INIT;
                            state_next = S_P_RD;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    OP_DEPTH:
                    begin
                        state_next = S_Q_TEST;
                    end
                    default:
                    begin
                        if (status.req_root)
                        begin
                            cmd.set_ok = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            state_next = S_T_TEST;
                        end
                    end
                endcase
            end
            S_APP_WR:
            begin
                cmd.code   = C_APP_WR;
                state_next = S_FIN;
            end
            // closure: take each gone node once and mark its children
            S_P_RD:
            begin
                if (status.p_end)
                begin
                    if (status.changed)
                    begin
                        cmd.code = C_PASS;
                    end
                    else
                    begin
                        state_next = S_C_INIT;
                    end
                end
                else
                begin
                    cmd.code   = C_P_RD;
                    state_next = S_P_CHK;
                end
            end
            S_P_CHK:
            begin
                if (status.p_live)
                begin
                    cmd.code   = C_P_TAKE;
                    state_next = S_I_RD;
                end
                else
                begin
                    cmd.code   = C_P_NEXT;
                    state_next = S_P_RD;
                end
            end
            S_I_RD:
            begin
                if (status.ptr_end)
                begin
                    cmd.code   = C_P_NEXT;
                    state_next = S_P_RD;
                end
                else
                begin
                    cmd.code   = C_I_RD;
                    state_next = S_I_CHK;
                end
            end
            S_I_CHK:
            begin
                cmd.code   = C_I_CHK;
                state_next = S_I_RD;
            end
            // order-keeping compaction
            S_C_INIT:
            begin
                cmd.code   = C_C_INIT;
                state_next = S_C_RD;
            end
            S_C_RD:
            begin
                if (status.ptr_end)
                begin
                    cmd.code   = C_C_END;
                    cmd.set_ok = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.code   = C_C_RD;
                    state_next = S_C_WR;
                end
            end
            S_C_WR:
            begin
                cmd.code   = C_C_WR;
                state_next = S_C_RD;
            end
            // ancestor climbs
            S_Q_TEST:
            begin
                if (status.key_neg1 || status.depth_max)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.code   = C_F_START;
                    state_next = S_F_RD;
                end
            end
            S_T_TEST:
            begin
                if (status.key_neg1 || status.step_max)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.code   = C_F_START;
                    state_next = S_F_RD;
                end
            end
            S_F_RD:
            begin
                if (status.ptr_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.code   = C_F_RD;
                    state_next = S_F_CHK;
                end
            end
            S_F_CHK:
            begin
                if (status.hit)
                begin
                    cmd.code = C_F_HIT;
                    if (status.op == OP_DEPTH)
                    begin
                        state_next = S_Q_TEST;
                    end
                    else if (status.hit_root)
                    begin
                        cmd.set_ok = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_T_TEST;
                    end
                end
                else
                begin
                    cmd.code   = C_I_NEXT;
                    state_next = S_F_RD;
                end
            end
            S_FIN:
            begin
                if (!status.out_busy)
                begin
                    cmd.code   = C_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/plft_datapath.sv -----
// node memories, pointers, flags and result register of the forest table
`include "parent_linked_forest_table_core_defines.svh"

module plft_datapath
    import plft_pkg::*;
#(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int MAX_DEPTH      = MAX_DEPTH_DEF,
    parameter int ANCESTOR_STEPS = ANCESTOR_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [1:0]         operation,
    input  logic signed [7:0]  node_index,
    input  logic signed [16:0] first_id_req,
    input  logic [15:0]        second_id,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [15:0]        value,
    output logic [7:0]         node_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int DMAX  = (MAX_DEPTH > ANCESTOR_STEPS) ? MAX_DEPTH : ANCESTOR_STEPS;
    localparam int DW    = $clog2(DMAX + 1);

    logic [15:0]        node_mem   [CAPACITY];
    logic signed [16:0] parent_mem [CAPACITY];
    logic [15:0]        rd_node_reg;
    logic signed [16:0] rd_parent_reg;

    logic [CW-1:0]      count_reg;
    logic [15:0]        next_id_reg;
    logic [1:0]         op_reg;
    logic signed [7:0]  idx_reg;
    logic signed [16:0] req_reg;
    logic [15:0]        root_reg;
    logic signed [16:0] key_reg;
    logic [DW-1:0]      depth_reg;
    logic [CW-1:0]      p_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      w_reg;
    logic [CAPACITY-1:0] gone_reg;
    logic [CAPACITY-1:0] done_reg;
    logic               changed_reg;
    logic               res_ok_reg;
    logic [15:0]        res_val_reg;
    logic               out_valid_reg;
    logic               ok_reg;
    logic [15:0]        value_reg;
    logic [7:0]         node_count_reg;

    logic [AW-1:0]      idx_addr;
    logic [AW-1:0]      p_addr;
    logic [AW-1:0]      i_addr;
    logic [AW-1:0]      w_addr;
    logic [AW-1:0]      cnt_addr;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [15:0]        wr_node;
    logic signed [16:0] wr_parent;
    logic               idx_ok;

    assign idx_addr = AW'(idx_reg[6:0]);
    assign p_addr   = p_reg[AW-1:0];
    assign i_addr   = i_reg[AW-1:0];
    assign w_addr   = w_reg[AW-1:0];
    assign cnt_addr = count_reg[AW-1:0];
    assign idx_ok   = !idx_reg[7] && (9'(idx_reg[6:0]) < 9'(count_reg));

    // read address and write port selection
    always_comb
    begin
        rd_addr   = i_addr;
        wr_en     = 1'b0;
        wr_addr   = w_addr;
        wr_node   = rd_node_reg;
        wr_parent = rd_parent_reg;
        case (cmd.code)
            C_APP_RD: rd_addr = idx_addr;
            C_P_RD:   rd_addr = p_addr;
            C_APP_WR:
            begin
                wr_en     = 1'b1;
                wr_addr   = cnt_addr;
                wr_node   = next_id_reg;
                wr_parent = idx_ok ? $signed({1'b0, rd_node_reg}) : ROOT_ID;
            end
            C_C_WR:   wr_en = !gone_reg[i_addr];
            default:  rd_addr = i_addr;
        endcase
    end

    // node memories, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            node_mem[wr_addr]   <= wr_node;
            parent_mem[wr_addr] <= wr_parent;
        end
        rd_node_reg   <= node_mem[rd_addr];
        rd_parent_reg <= parent_mem[rd_addr];
    end

    // status to the controller
    always_comb
    begin
        status.op        = op_reg;
        status.idx_ok    = idx_ok;
        status.full      = (count_reg == CW'(CAPACITY));
        status.ptr_end   = (i_reg >= count_reg);
        status.p_end     = (p_reg >= count_reg);
        status.p_live    = gone_reg[p_addr] && !done_reg[p_addr];
        status.hit       = !key_reg[16] && (rd_node_reg == key_reg[15:0]);
        status.hit_root  = (rd_parent_reg == $signed({1'b0, root_reg}));
        status.key_neg1  = (key_reg == ROOT_ID);
        status.depth_max = (depth_reg == DW'(MAX_DEPTH));
        status.step_max  = (depth_reg == DW'(ANCESTOR_STEPS));
        status.req_root  = (req_reg == $signed({1'b0, root_reg}));
        status.out_busy  = out_valid_reg && out_stall;
        status.changed   = changed_reg;
    end

    // request fields, climb key and pointers
    always_ff @(posedge clk)
    begin
        case (cmd.code)
            C_LOAD:
            begin
                op_reg    <= operation;
                idx_reg   <= node_index;
                req_reg   <= first_id_req;
                root_reg  <= second_id;
                key_reg   <= first_id_req;
                depth_reg <= '0;
            end
            C_DEL_INIT:
            begin
                p_reg <= '0;
            end
            C_P_TAKE:
            begin
                key_reg <= $signed({1'b0, rd_node_reg});
                i_reg   <= '0;
            end
            C_P_NEXT: p_reg <= p_reg + 1'b1;
            C_PASS:   p_reg <= '0;
            C_I_CHK:  i_reg <= i_reg + 1'b1;
            C_C_INIT:
            begin
                i_reg <= '0;
                w_reg <= '0;
            end
            C_C_WR:
            begin
                i_reg <= i_reg + 1'b1;
                if (!gone_reg[i_addr])
                begin
                    w_reg <= w_reg + 1'b1;
                end
            end
            C_F_START:
            begin
                depth_reg <= depth_reg + 1'b1;
                i_reg     <= '0;
            end
            C_F_HIT:  key_reg <= rd_parent_reg;
            C_I_NEXT: i_reg   <= i_reg + 1'b1;
            default:  ;
        endcase
    end

    // table control state: count, id counter, delete flags, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            next_id_reg   <= '0;
            gone_reg      <= '0;
            done_reg      <= '0;
            changed_reg   <= 1'b0;
            res_ok_reg    <= 1'b0;
            res_val_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                next_id_reg <= cfg_wdata;
            end
            // result valid: set on finish, cleared once taken
            if (cmd.code == C_FIN)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.set_ok)
            begin
                res_ok_reg <= 1'b1;
            end
            case (cmd.code)
                C_LOAD:
                begin
                    res_ok_reg  <= (operation == OP_DEPTH);
                    res_val_reg <= '0;
                end
                C_APP_WR:
                begin
                    res_ok_reg  <= 1'b1;
                    res_val_reg <= next_id_reg;
                    next_id_reg <= next_id_reg + 1'b1;
                    count_reg   <= count_reg + 1'b1;
                end
                C_DEL_INIT:
                begin
                    gone_reg    <= CAPACITY'(1) << idx_addr;
                    done_reg    <= '0;
                    changed_reg <= 1'b0;
                end
                C_P_TAKE:
                begin
                    done_reg[p_addr] <= 1'b1;
                    changed_reg      <= 1'b1;
                end
                C_PASS:   changed_reg <= 1'b0;
                C_I_CHK:
                begin
                    if (!gone_reg[i_addr] &&
                        rd_parent_reg == key_reg)
                    begin
                        gone_reg[i_addr] <= 1'b1;
                    end
                end
                C_C_END:  count_reg <= w_reg;
                default:  ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.code == C_FIN)
        begin
            ok_reg         <= res_ok_reg;
            value_reg      <= (op_reg == OP_DEPTH) ? 16'(depth_reg) : res_val_reg;
            node_count_reg <= 8'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign ok         = ok_reg;
    assign value      = value_reg;
    assign node_count = node_count_reg;

    `PLFT_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY))
    `PLFT_ASSERT_NXT(a_fin_valid, clk, rst_n, cmd.code == C_FIN, out_valid_reg)
    `PLFT_ASSERT_IMP(a_compact_order, clk, rst_n, cmd.code == C_C_WR, w_reg <= i_reg)
    `PLFT_ASSERT_IMP(a_fin_free, clk, rst_n, cmd.code == C_FIN, !(out_valid_reg && out_stall))

endmodule

// ----- rtl/parent_linked_forest_table_core.sv -----
// Forest table: one request at a time, result through an output register.
// Append reads the parent entry and writes the new node; depth and subtree
// tests scan the node memories through the single read port for each
// ancestor step. Delete rescans the table for each removed node, repeats
// passes until nothing changes, then compacts. Reset clears count, id counter
// and flags at once; the node memories are not cleared, entries above count are never used.
module parent_linked_forest_table_core
    import plft_pkg::*;
#(
    parameter int CAPACITY       = CAPACITY_DEF,
    parameter int MAX_DEPTH      = MAX_DEPTH_DEF,
    parameter int ANCESTOR_STEPS = ANCESTOR_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic signed [7:0]  node_index,
    input  logic signed [16:0] first_id_req,
    input  logic [15:0]        second_id,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               ok,
    output logic [15:0]        value,
    output logic [7:0]         node_count,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    // sequencing
    plft_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // storage and arithmetic
    plft_datapath
    #(
        .CAPACITY       (CAPACITY),
        .MAX_DEPTH      (MAX_DEPTH),
        .ANCESTOR_STEPS (ANCESTOR_STEPS)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .node_index   (node_index),
        .first_id_req (first_id_req),
        .second_id    (second_id),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .value        (value),
        .node_count   (node_count)
    );

endmodule

// ----- bench/tb_parent_linked_forest_table_core.sv -----
// self-checking testbench for the parent-linked forest table core
module tb_parent_linked_forest_table_core
    import plft_pkg::*;
();

    localparam int CAP       = 128;
    localparam int DEPTH_CAP = 16;
    localparam int ANC_STEPS = 10;

    typedef struct {
        logic [1:0]         op;
        logic signed [7:0]  idx;
        logic signed [16:0] req;
        logic [15:0]        root;
    } forest_req_t;

    typedef struct {
        logic        ok;
        logic [15:0] value;
        logic [7:0]  cnt;
    } forest_resp_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         operation;
    logic signed [7:0]  node_index;
    logic signed [16:0] first_id_req;
    logic [15:0]        second_id;
    logic               out_valid;
    logic               out_stall;
    logic               ok;
    logic [15:0]        value;
    logic [7:0]         node_count;
    logic               cfg_we;
    logic [15:0]        cfg_wdata;

    parent_linked_forest_table_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .node_index   (node_index),
        .first_id_req (first_id_req),
        .second_id    (second_id),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .value        (value),
        .node_count   (node_count),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    // shadow forest state
    logic [15:0]        tbl_id [CAP];
    logic signed [16:0] tbl_par [CAP];
    int                 tbl_count;
    logic [15:0]        id_counter;

    forest_req_t  pending_q [$];
    forest_resp_t resp_q [$];
    forest_req_t  cur_req;
    bit           holding;
    bit           quiet;
    bit           pressed;
    int           errors;
    int           n_accepted;
    int           in_gap;
    int           stall_left;
    int           press_left;

    // clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic int slot_of(int id);
        if (id < 0)
            return -1;
        for (int i = 0; i < tbl_count; i++)
            if (int'(tbl_id[i]) == id)
                return i;
        return -1;
    endfunction

    function automatic int climb_depth(int start);
        int d;
        int cur;
        int s;
        d = 0;
        cur = start;
        while (cur != -1 && d < DEPTH_CAP)
        begin
            d++;
            s = slot_of(cur);
            if (s < 0)
                break;
            cur = tbl_par[s];
        end
        return d;
    endfunction

    function automatic bit descends_from(int child, int root);
        int cur;
        int s;
        cur = child;
        if (child == root)
            return 1'b1;
        for (int step = 0; step < ANC_STEPS && cur != -1; step++)
        begin
            s = slot_of(cur);
            if (s >= 0)
                cur = tbl_par[s];
            if (cur == root)
                return 1'b1;
            if (s < 0)
                break;
        end
        return 1'b0;
    endfunction

    // cascading delete followed by in-order compaction
    function automatic void cascade_remove(int target);
        bit gone [CAP];
        bit changed;
        int w;
        for (int i = 0; i < CAP; i++)
            gone[i] = 1'b0;
        gone[target] = 1'b1;
        do
        begin
            changed = 1'b0;
            for (int i = 0; i < tbl_count; i++)
            begin
                if (!gone[i])
                begin
                    for (int p = 0; p < tbl_count; p++)
                    begin
                        if (gone[p] && tbl_par[i] == $signed({1'b0, tbl_id[p]}))
                        begin
                            gone[i] = 1'b1;
                            changed = 1'b1;
                            break;
                        end
                    end
                end
            end
        end
        while (changed);
        w = 0;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (!gone[i])
            begin
                tbl_id[w] = tbl_id[i];
                tbl_par[w] = tbl_par[i];
                w++;
            end
        end
        tbl_count = w;
    endfunction

    function automatic forest_resp_t predict_forest(forest_req_t rq);
        forest_resp_t rs;
        int idx;
        rs.ok = 1'b0;
        rs.value = '0;
        idx = rq.idx;
        case (rq.op)
            OP_APPEND:
            begin
                if (tbl_count < CAP)
                begin
                    tbl_par[tbl_count] = ROOT_ID;
                    if (idx >= 0 && idx < tbl_count)
                        tbl_par[tbl_count] = $signed({1'b0, tbl_id[idx]});
                    tbl_id[tbl_count] = id_counter;
                    rs.value = id_counter;
                    id_counter = id_counter + 16'd1;
                    tbl_count++;
                    rs.ok = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (idx >= 0 && idx < tbl_count)
                begin
                    cascade_remove(idx);
                    rs.ok = 1'b1;
                end
            end
            OP_DEPTH:
            begin
                rs.value = 16'(climb_depth(rq.req));
                rs.ok = 1'b1;
            end
            default:
                rs.ok = descends_from(rq.req, int'(rq.root));
        endcase
        rs.cnt = 8'(tbl_count);
        return rs;
    endfunction

    // prediction on each accepted request and on register writes
    always @(posedge clk)
    begin
        if (rst_n && cfg_we)
            id_counter = cfg_wdata;
        if (rst_n && in_valid && !in_stall)
        begin
            resp_q.push_back(predict_forest(cur_req));
            holding = 1'b0;
            n_accepted++;
        end
    end

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && !holding)
        begin
            if (in_gap > 0)
            begin
                in_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0)
            begin
                cur_req = pending_q.pop_front();
                operation <= cur_req.op;
                node_index <= cur_req.idx;
                first_id_req <= cur_req.req;
                second_id <= cur_req.root;
                in_valid <= 1'b1;
                holding = 1'b1;
                in_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result stall, with one long hold-off while requests keep coming
    always @(negedge clk)
    begin
        if (press_left > 0)
        begin
            press_left--;
            out_stall <= 1'b1;
        end
        else if (!pressed && n_accepted >= 200)
        begin
            pressed = 1'b1;
            press_left = 300;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            out_stall <= (stall_left > 0);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        forest_resp_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (resp_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result ok=%0d value=%0d count=%0d",
                         $time, ok, value, node_count);
            end
            else
            begin
                exp_r = resp_q.pop_front();
                if (ok !== exp_r.ok)
                begin
                    errors++;
                    $display("%0t: ok expected %0d actual %0d", $time, exp_r.ok, ok);
                end
                if (value !== exp_r.value)
                begin
                    errors++;
                    $display("%0t: value expected %0d actual %0d",
                             $time, exp_r.value, value);
                end
                if (node_count !== exp_r.cnt)
                begin
                    errors++;
                    $display("%0t: node_count expected %0d actual %0d",
                             $time, exp_r.cnt, node_count);
                end
            end
        end
    end

    task automatic add_req(logic [1:0] op, int idx, int req, int root);
        forest_req_t rq;
        rq.op = op;
        rq.idx = 8'(idx);
        rq.req = 17'(req);
        rq.root = 16'(root);
        pending_q.push_back(rq);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_q.size() > 0 || holding || resp_q.size() > 0);
    endtask

    task automatic write_first_id(logic [15:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // random request around the ids issued since base
    task automatic add_random(int base, int span);
        int r;
        int idr;
        r = $urandom_range(0, 99);
        idr = (base + $urandom_range(0, span)) & 16'hffff;
        if ($urandom_range(0, 9) == 0)
            idr = -1;
        else if ($urandom_range(0, 9) == 0)
            idr = $urandom_range(0, 65535);
        if (r < 40)
            add_req(OP_APPEND, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                    : $urandom_range(0, span), 0, 0);
        else if (r < 55)
            add_req(OP_DELETE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                    : $urandom_range(0, span / 2), 0, 0);
        else if (r < 75)
            add_req(OP_DEPTH, 0, idr, 0);
        else
            add_req(OP_SUBTREE, 0, idr,
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                    : (base + $urandom_range(0, span)) & 16'hffff);
    endtask

    // stimulus phases
    initial
    begin
        int base;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        operation = OP_APPEND;
        node_index = '0;
        first_id_req = '0;
        second_id = '0;
        holding = 1'b0;
        quiet = 1'b0;
        pressed = 1'b0;
        errors = 0;
        n_accepted = 0;
        in_gap = 0;
        stall_left = 0;
        press_left = 0;
        tbl_count = 0;
        id_counter = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: counter wrap, out-of-range indexes, query corner cases
        write_first_id(16'd65533);
        add_req(OP_DEPTH, 0, -1, 0);
        add_req(OP_APPEND, -1, 0, 0);
        add_req(OP_APPEND, 0, 0, 0);
        add_req(OP_APPEND, 1, 0, 0);
        add_req(OP_APPEND, 127, 0, 0);
        add_req(OP_APPEND, 2, 0, 0);
        add_req(OP_DEPTH, 0, 65535, 0);
        add_req(OP_DEPTH, 0, 0, 0);
        add_req(OP_DEPTH, 0, 1, 0);
        add_req(OP_DEPTH, 0, 777, 0);
        add_req(OP_SUBTREE, 0, 0, 65533);
        add_req(OP_SUBTREE, 0, 65534, 65534);
        add_req(OP_SUBTREE, 0, -1, 65535);
        add_req(OP_SUBTREE, 0, 777, 0);
        add_req(OP_SUBTREE, 0, 65533, 0);
        add_req(OP_DELETE, -1, 0, 0);
        add_req(OP_DELETE, 127, 0, 0);
        add_req(OP_DELETE, -128, 0, 0);
        add_req(OP_DELETE, 1, 0, 0);
        add_req(OP_DEPTH, 0, 1, 0);
        add_req(OP_DELETE, 0, 0, 0);
        add_req(OP_DELETE, 0, 0, 0);

        // fill past capacity, then work on a full table
        write_first_id(16'd0);
        quiet = 1'b1;
        for (int i = 0; i < 130; i++)
            add_req(OP_APPEND, (i < 20) ? i - 1 : $urandom_range(0, i + 4), 0, 0);
        quiet = 1'b0;
        add_req(OP_DEPTH, 0, 19, 0);
        add_req(OP_SUBTREE, 0, 19, 0);
        add_req(OP_SUBTREE, 0, 19, 8);
        add_req(OP_SUBTREE, 0, 19, 9);
        for (int i = 0; i < 16; i++)
            add_random(0, 127);
        wait_idle();

        // random mix from a random start id, chains favoured
        base = $urandom_range(0, 65535);
        write_first_id(16'(base));
        add_req(OP_DELETE, 0, 0, 0);
        for (int i = 0; i < 110; i++)
        begin
            if ($urandom_range(0, 3) == 0)
                add_req(OP_APPEND, 127, 0, 0);
            else
                add_random(base, 40);
        end

        // top of the counter range
        write_first_id(16'hffff);
        for (int i = 0; i < 15; i++)
            add_random(16'hffff, 12);

        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0 && resp_q.size() == 0)
            $display("tb_parent_linked_forest_table_core OK");
        else
            $display("tb_parent_linked_forest_table_core NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000000;
        $display("tb_parent_linked_forest_table_core NOT OK");
        $finish;
    end

endmodule
